// ----- src/potm_pkg.sv -----
// ----------------------------------------------------------------------------
// potm_pkg: shared constants for the occurrence-threshold merge
// Field widths, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package potm_pkg;

  localparam int ID_W        = 6;   // item id / candidate id
  localparam int ID_SPAN     = 64;  // ids the id field can name
  localparam int LIM_W       = 7;   // items_in_use
  localparam int MINC_W      = 8;   // min_count
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam int MAX_ITEMS_DEF   = 64;
  localparam int COUNT_WIDTH_DEF = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ITEMS_IN_USE = 1'b1;

  localparam logic [MINC_W-1:0] MIN_COUNT_RST    = 8'd2;
  localparam logic [LIM_W-1:0]  ITEMS_IN_USE_RST = 7'd64;

endpackage

// ----- src/potm_posting_if.sv -----
// ----------------------------------------------------------------------------
// potm_posting_if: posting id request channel
// One item id per request, with the end-of-query mark.
// ----------------------------------------------------------------------------
interface potm_posting_if import potm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] item_id;
  logic            last_of_query;

  modport source (output valid, output item_id, output last_of_query, input ready);
  modport sink   (input valid, input item_id, input last_of_query, output ready);
endinterface

// ----- src/potm_result_if.sv -----
// ----------------------------------------------------------------------------
// potm_result_if: candidate result channel
// One candidate id per request, last_result on the final one of a query.
// ----------------------------------------------------------------------------
interface potm_result_if import potm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] cand_id;
  logic            cand_valid;
  logic            last_result;

  modport source (output valid, output cand_id, output cand_valid, output last_result,
                  input ready);
  modport sink   (input valid, input cand_id, input cand_valid, input last_result,
                  output ready);
endinterface

// ----- src/potm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// potm_cfg_if: configuration write channel
// Register index and write data per request.
// ----------------------------------------------------------------------------
interface potm_cfg_if import potm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/posting_occurrence_threshold_merge_top.sv -----
// ----------------------------------------------------------------------------
// posting_occurrence_threshold_merge_top: occurrence-threshold posting merge
// Counts posting ids of one query and emits the ids that occur often enough.
// ----------------------------------------------------------------------------
// Usage:
//   posting: one item id per request; last_of_query closes the query.
//     Ids at or above items_in_use (or the store depth) are dropped.
//   result:  after the closing request, every id whose count reaches
//     min_count, ascending, last_result on the final one. An empty answer is
//     one request with cand_valid 0 and last_result 1.
//   cfg:     register writes (min_count, items_in_use), always ready; write
//     only while no query is in flight.
// Flow: ids are taken one per cycle while a query is counted
//   (read-modify-write of the counter memory, registered read, forwarding on
//   repeated ids). The closing request starts a scan of the counter memory
//   that reads each entry, then checks and clears it; DEPTH = min(MAX_ITEMS, 64).
//   No ids are taken during the scan.
// Reset: registers take their defaults and the counter memory is cleared in
//   a pass over every entry; posting.ready stays low until it completes.
// Stall: a result waits in the output register; the scan halts while a
//   second candidate is found and the register is still full.
// ----------------------------------------------------------------------------
module posting_occurrence_threshold_merge_top import potm_pkg::*; #(
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  potm_posting_if.sink  posting,
  potm_result_if.source result,
  potm_cfg_if.sink      cfg
);

  localparam int DEPTH = (MAX_ITEMS < ID_SPAN) ? MAX_ITEMS : ID_SPAN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [MINC_W-1:0]      min_count;
  logic [LIM_W-1:0]       items_in_use;
  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [COUNT_WIDTH-1:0] rd_data, wr_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_count    <= MIN_COUNT_RST;
      items_in_use <= ITEMS_IN_USE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MIN_COUNT:    min_count    <= cfg.data[MINC_W-1:0];
        REG_ITEMS_IN_USE: items_in_use <= cfg.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  potm_ctrl #(
    .MAX_ITEMS   (MAX_ITEMS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .DEPTH       (DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .min_count    (min_count),
    .items_in_use (items_in_use),
    .posting      (posting),
    .result       (result),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  potm_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (COUNT_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

// ----- src/potm_mem.sv -----
// ----------------------------------------------------------------------------
// potm_mem: occurrence counter store
// One write port, one read port, registered read data (read before write).
// ----------------------------------------------------------------------------
module potm_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 8
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [CW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [CW-1:0] wr_data
);

  logic [CW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ----- src/potm_ctrl.sv -----
// ----------------------------------------------------------------------------
// potm_ctrl: count update pipeline and threshold scan
// Read-modify-write of the counters with forwarding, then a clearing scan.
// ----------------------------------------------------------------------------
module potm_ctrl import potm_pkg::*; #(
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int DEPTH       = (MAX_ITEMS < ID_SPAN) ? MAX_ITEMS : ID_SPAN,
  parameter int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [MINC_W-1:0]      min_count,
  input  logic [LIM_W-1:0]       items_in_use,
  potm_posting_if.sink           posting,
  potm_result_if.source          result,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  logic [COUNT_WIDTH-1:0] rd_data,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [COUNT_WIDTH-1:0] wr_data
);

  localparam int CMP_W = (COUNT_WIDTH > MINC_W) ? COUNT_WIDTH : MINC_W;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(DEPTH);

  typedef enum logic [2:0] {S_CLR, S_ACC, S_RD, S_CHK, S_FIN} state_t;

  state_t                 state;
  logic [AW-1:0]          scan_addr;
  logic                   p_valid, p_ok, p_last;
  logic [AW-1:0]          p_addr;
  logic                   fwd_valid;
  logic [AW-1:0]          fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;
  logic                   pend_valid;
  logic [ID_W-1:0]        pend_id;
  logic                   o_valid, o_cv, o_last;
  logic [ID_W-1:0]        o_id;

  logic                   accept, id_ok, acc_wr, out_free, hit, chk_go, o_load;
  logic [LIM_W-1:0]       lim;
  logic [COUNT_WIDTH-1:0] cur, inc;

  assign lim = (items_in_use > DEPTH_LIM) ? DEPTH_LIM : items_in_use;

  assign posting.ready = (state == S_ACC) && !(p_valid && p_last);
  assign accept        = posting.valid && posting.ready;
  assign id_ok         = LIM_W'(posting.item_id) < lim;

  assign rd_en   = accept || (state == S_RD);
  assign rd_addr = (state == S_RD) ? scan_addr : posting.item_id[AW-1:0];

  // back-to-back hit on the same counter: take the value just written
  assign cur = (fwd_valid && fwd_addr == p_addr) ? fwd_data : rd_data;
  assign inc = (&cur) ? cur : cur + COUNT_WIDTH'(1);

  assign acc_wr   = (state == S_ACC) && p_valid && p_ok;
  assign out_free = !o_valid || result.ready;
  assign hit      = (CMP_W'(rd_data) >= CMP_W'(min_count)) && (LIM_W'(scan_addr) < lim);
  // a second hit must push the held one out first
  assign chk_go   = (state == S_CHK) && (!(hit && pend_valid) || out_free);
  assign o_load   = (chk_go && hit && pend_valid) || ((state == S_FIN) && out_free);

  assign wr_en   = acc_wr || (state == S_CLR) || chk_go;
  assign wr_addr = acc_wr ? p_addr : scan_addr;
  assign wr_data = acc_wr ? inc : '0;

  assign result.valid       = o_valid;
  assign result.cand_id     = o_id;
  assign result.cand_valid  = o_cv;
  assign result.last_result = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      scan_addr  <= '0;
      p_valid    <= 1'b0;
      fwd_valid  <= 1'b0;
      pend_valid <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end

      fwd_valid <= acc_wr;
      fwd_addr  <= p_addr;
      fwd_data  <= inc;

      p_valid <= accept;
      if (accept) begin
        p_ok   <= id_ok;
        p_last <= posting.last_of_query;
        p_addr <= posting.item_id[AW-1:0];
      end

      case (state)
        S_CLR: begin
          if (scan_addr == LAST_ADDR) begin
            scan_addr <= '0;
            state     <= S_ACC;
          end else begin
            scan_addr <= scan_addr + AW'(1);
          end
        end
        S_ACC: begin
          if (p_valid && p_last) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (chk_go) begin
            if (hit) begin
              if (pend_valid) begin
                o_id   <= pend_id;
                o_cv   <= 1'b1;
                o_last <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_id    <= ID_W'(scan_addr);
            end
            if (scan_addr == LAST_ADDR) begin
              scan_addr <= '0;
              state     <= S_FIN;
            end else begin
              scan_addr <= scan_addr + AW'(1);
              state     <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            o_id       <= pend_valid ? pend_id : '0;
            o_cv       <= pend_valid;
            o_last     <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_ACC;
          end
        end
        default: begin
          state <= S_CLR;
        end
      endcase
    end
  end

endmodule
